>>> rtl/core/record_table_sort_search_macros.svh
// Assertion macros for the record table sort and search block.
// Used by record_table_sort_search; expects clk_i and rst_ni in scope.
`ifndef RECORD_TABLE_SORT_SEARCH_MACROS_SVH
`define RECORD_TABLE_SORT_SEARCH_MACROS_SVH

// same-cycle implication
`define RTSS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtss assertion failed");

// next-cycle implication
`define RTSS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtss assertion failed");

`endif

>>> rtl/core/rtss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the record table sort and search block.
// No dependencies.
package rtss_pkg;

  localparam int unsigned DEF_CAPACITY = 128;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned KEY_W   = 34;
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned AMT_W   = 32;
  localparam int unsigned RIDX_W  = 7;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned HELD_W  = 8;

  typedef enum logic [FUNC_W-1:0] {
    F_CLEAR  = 3'd0,
    F_APPEND = 3'd1,
    F_SORT   = 3'd2,
    F_LINEAR = 3'd3,
    F_BINARY = 3'd4,
    F_READ   = 3'd5
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  typedef struct packed {
    logic        [KEY_W-1:0] key;
    logic        [TAG_W-1:0] tag;
    logic signed [AMT_W-1:0] cents;
  } rec_t;

endpackage

>>> rtl/core/rtss_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the record table block.
// Depends on rtss_pkg.
interface rtss_in_if;
  logic                               valid;
  logic                               ready;
  logic        [rtss_pkg::FUNC_W-1:0] func;
  logic        [rtss_pkg::KEY_W-1:0]  search_key;
  logic        [rtss_pkg::TAG_W-1:0]  name_tag;
  logic signed [rtss_pkg::AMT_W-1:0]  bill_cents;
  logic        [rtss_pkg::RIDX_W-1:0] read_index;

  modport source (output valid, func, search_key, name_tag, bill_cents, read_index,
                  input ready);
  modport sink (input valid, func, search_key, name_tag, bill_cents, read_index,
                output ready);
endinterface

interface rtss_out_if;
  logic                               valid;
  logic                               ready;
  logic        [rtss_pkg::STAT_W-1:0] status;
  logic        [rtss_pkg::RIDX_W-1:0] found_index;
  logic        [rtss_pkg::KEY_W-1:0]  record_key;
  logic        [rtss_pkg::TAG_W-1:0]  record_tag;
  logic signed [rtss_pkg::AMT_W-1:0]  record_cents;
  logic        [rtss_pkg::HELD_W-1:0] entries_held;

  modport source (output valid, status, found_index, record_key, record_tag,
                  record_cents, entries_held, input ready);
  modport sink (input valid, status, found_index, record_key, record_tag,
                record_cents, entries_held, output ready);
endinterface

>>> rtl/core/record_table_sort_search.sv
`timescale 1ns / 1ps
// Linear search reads records in turn until a key matches or the table ends; binary search
// halves the range per probe; sort partitions with a range stack, swapping and pushing ranges.
// Throughput: one request at a time; the request channel is ready only while idle.
// Reset clears the record count and control; the memories are not cleared.
// Record table with quicksort and search; depends on rtss_pkg and rtss_if.
`include "record_table_sort_search_macros.svh"

module record_table_sort_search #(
  parameter int unsigned CAPACITY = rtss_pkg::DEF_CAPACITY
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  rtss_in_if.sink         req_i,
  rtss_out_if.source      rsp_o
);
  import rtss_pkg::*;

  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned BW   = IW + 2;
  localparam int unsigned CMPW = (CW > RIDX_W) ? CW : RIDX_W;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_LIN, S_BIN_RD, S_BIN_CMP, S_POP, S_POP_W, S_PIV, S_PIV_W,
    S_CHK, S_SCAN_I, S_SCAN_J, S_SW1, S_SW2, S_FIN1, S_FIN2, S_PUSH2, S_RES
  } state_e;

  state_e state_q;

  rec_t rec_mem [CAPACITY];
  logic [2*IW-1:0] stk_mem [CAPACITY];

  rec_t            rd_q;
  logic [2*IW-1:0] stk_rd_q;

  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  rec_t            mem_wdata;
  logic [IW-1:0]   mem_raddr;
  logic            stk_we;
  logic [IW-1:0]   stk_waddr;
  logic [2*IW-1:0] stk_wdata;
  logic [IW-1:0]   stk_raddr;

  logic [CW-1:0]         count_q;
  logic [CW-1:0]         top_q;
  logic [CW-1:0]         i_q;
  logic [IW-1:0]         j_q;
  logic [IW-1:0]         lo_q;
  logic [IW-1:0]         hi_q;
  logic [IW-1:0]         mid_q;
  logic signed [BW-1:0]  bin_lo_q;
  logic signed [BW-1:0]  bin_hi_q;
  logic signed [BW-1:0]  bin_sum;
  logic [IW-1:0]         bin_mid;
  logic [KEY_W-1:0]      key_q;
  rec_t                  piv_q;
  rec_t                  rec_i_q;
  rec_t                  rec_j_q;

  status_e               res_status_q;
  logic [IW-1:0]         res_idx_q;
  rec_t                  res_rec_q;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [RIDX_W-1:0]     out_idx_q;
  rec_t                  out_rec_q;
  logic [HELD_W-1:0]     out_held_q;

  logic in_fire;
  logic adv_i;
  logic push_hi;
  logic push_lo;
  logic top_room;

  assign in_fire  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  assign bin_sum  = bin_lo_q + bin_hi_q;
  assign bin_mid  = bin_sum[IW:1];
  assign adv_i    = (rd_q.key <= piv_q.key) && (i_q < CW'(hi_q));
  assign top_room = (top_q < CW'(CAPACITY));
  assign push_hi  = (({1'b0, j_q} + 1'b1) < {1'b0, hi_q}) && top_room;
  assign push_lo  = (({1'b0, lo_q} + 1'b1) < {1'b0, j_q}) && top_room;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rec_j_q;
    mem_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = IW'(top_q);
    stk_wdata = {lo_q, IW'(j_q - 1'b1)};
    stk_raddr = IW'(top_q - 1'b1);
    case (state_q)
      S_IDLE: begin
        mem_raddr = (req_i.func == F_READ) ? IW'(req_i.read_index) : '0;
        mem_waddr = IW'(count_q);
        mem_wdata = '{key: req_i.search_key, tag: req_i.name_tag,
                      cents: req_i.bill_cents};
        mem_we    = in_fire && (req_i.func == F_APPEND) && (count_q != CW'(CAPACITY));
      end
      S_LIN:    mem_raddr = IW'(i_q + 1'b1);
      S_BIN_RD: mem_raddr = bin_mid;
      S_PIV:    mem_raddr = lo_q;
      S_CHK:    mem_raddr = IW'(i_q);
      S_SCAN_I: mem_raddr = adv_i ? IW'(i_q + 1'b1) : j_q;
      S_SCAN_J: mem_raddr = j_q - 1'b1;
      S_SW1: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(i_q);
        mem_wdata = rec_j_q;
      end
      S_SW2: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = rec_i_q;
      end
      S_FIN1: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q;
        mem_wdata = rec_j_q;
      end
      S_FIN2: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = piv_q;
        stk_we    = push_hi;
        stk_wdata = {IW'(j_q + 1'b1), hi_q};
      end
      S_PUSH2:  stk_we = push_lo;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rec_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= rec_mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            res_status_q <= ST_OK;
            res_idx_q    <= '0;
            res_rec_q    <= '0;
            key_q        <= req_i.search_key;
            state_q      <= S_RES;
            case (req_i.func)
              F_CLEAR: count_q <= '0;
              F_APPEND: begin
                if (count_q == CW'(CAPACITY)) begin
                  res_status_q <= ST_FULL;
                end else begin
                  count_q <= count_q + 1'b1;
                end
              end
              F_SORT: begin
                if (count_q >= CW'(2)) begin
                  lo_q    <= '0;
                  hi_q    <= IW'(count_q - 1'b1);
                  top_q   <= '0;
                  state_q <= S_PIV;
                end
              end
              F_LINEAR: begin
                if (count_q == '0) begin
                  res_status_q <= ST_NOT_FOUND;
                end else begin
                  i_q     <= '0;
                  state_q <= S_LIN;
                end
              end
              F_BINARY: begin
                bin_lo_q <= '0;
                bin_hi_q <= $signed(BW'(count_q) - BW'(1));
                state_q  <= S_BIN_RD;
              end
              F_READ: begin
                if (CMPW'(req_i.read_index) >= CMPW'(count_q)) begin
                  res_status_q <= ST_RANGE;
                end else begin
                  i_q     <= CW'(req_i.read_index);
                  state_q <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          res_rec_q <= rd_q;
          res_idx_q <= IW'(i_q);
          state_q   <= S_RES;
        end
        S_LIN: begin
          if (rd_q.key == key_q) begin
            res_rec_q <= rd_q;
            res_idx_q <= IW'(i_q);
            state_q   <= S_RES;
          end else if ((i_q + 1'b1) == count_q) begin
            res_status_q <= ST_NOT_FOUND;
            state_q      <= S_RES;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_BIN_RD: begin
          if (bin_lo_q <= bin_hi_q) begin
            mid_q   <= bin_mid;
            state_q <= S_BIN_CMP;
          end else begin
            res_status_q <= ST_NOT_FOUND;
            state_q      <= S_RES;
          end
        end
        S_BIN_CMP: begin
          if (rd_q.key == key_q) begin
            res_rec_q <= rd_q;
            res_idx_q <= mid_q;
            state_q   <= S_RES;
          end else begin
            if (rd_q.key < key_q) begin
              bin_lo_q <= $signed({2'b00, mid_q} + BW'(1));
            end else begin
              bin_hi_q <= $signed({2'b00, mid_q} - BW'(1));
            end
            state_q <= S_BIN_RD;
          end
        end
        S_POP: begin
          if (top_q == '0) begin
            state_q <= S_RES;
          end else begin
            top_q   <= top_q - 1'b1;
            state_q <= S_POP_W;
          end
        end
        S_POP_W: begin
          lo_q    <= stk_rd_q[2*IW-1:IW];
          hi_q    <= stk_rd_q[IW-1:0];
          state_q <= (stk_rd_q[2*IW-1:IW] >= stk_rd_q[IW-1:0]) ? S_POP : S_PIV;
        end
        S_PIV:   state_q <= S_PIV_W;
        S_PIV_W: begin
          piv_q   <= rd_q;
          i_q     <= CW'(lo_q);
          j_q     <= hi_q;
          state_q <= S_CHK;
        end
        S_CHK:   state_q <= S_SCAN_I;
        S_SCAN_I: begin
          if (adv_i) begin
            i_q <= i_q + 1'b1;
          end else begin
            rec_i_q <= rd_q;
            state_q <= S_SCAN_J;
          end
        end
        S_SCAN_J: begin
          if (rd_q.key > piv_q.key) begin
            j_q <= j_q - 1'b1;
          end else begin
            rec_j_q <= rd_q;
            state_q <= (i_q < CW'(j_q)) ? S_SW1 : S_FIN1;
          end
        end
        S_SW1:  state_q <= S_SW2;
        S_SW2:  state_q <= S_CHK;
        S_FIN1: state_q <= S_FIN2;
        S_FIN2: begin
          if (push_hi) begin
            top_q <= top_q + 1'b1;
          end
          state_q <= S_PUSH2;
        end
        S_PUSH2: begin
          if (push_lo) begin
            top_q <= top_q + 1'b1;
          end
          state_q <= S_POP;
        end
        S_RES: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_idx_q    <= RIDX_W'(res_idx_q);
            out_rec_q    <= res_rec_q;
            out_held_q   <= HELD_W'(count_q);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.found_index  = out_idx_q;
  assign rsp_o.record_key   = out_rec_q.key;
  assign rsp_o.record_tag   = out_rec_q.tag;
  assign rsp_o.record_cents = out_rec_q.cents;
  assign rsp_o.entries_held = out_held_q;

  `RTSS_ASSERT_NOW(a_count_max, 1'b1, count_q <= CW'(CAPACITY))
  `RTSS_ASSERT_NOW(a_write_in_table, mem_we, CW'(mem_waddr) <= count_q)
  `RTSS_ASSERT_NOW(a_scan_j_floor, state_q == S_SCAN_J, j_q >= lo_q)
  `RTSS_ASSERT_NEXT(a_clear_empties, in_fire && (req_i.func == F_CLEAR), count_q == '0)

endmodule
